[rtl/core/assert_macros.svh]
// assertion macros used by the checker file mcr_checker.sv
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mcr_pkg.sv]
// constants, codes and types of the midpoint circle rasterizer
// no dependencies
package mcr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int OFFSET_BITS   = COORD_BITS + 1;
  localparam int DECISION_BITS = COORD_BITS + 4;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int SUM_BITS      = 2 * DIFF_BITS;
  localparam int PIXEL_BITS    = 14;
  localparam int COLOR_BITS    = 24;
  localparam int MIRROR_BITS   = 3;
  localparam int CALC_BITS     = (PIXEL_BITS > OFFSET_BITS + 1) ? PIXEL_BITS : OFFSET_BITS + 1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [MIRROR_BITS-1:0] LAST_MIRROR = {MIRROR_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_DX,
    ST_SQ_DY,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage

[rtl/core/mcr_cmd_if.sv]
// command channel: valid/ready handshake with start/step payload
// depends on mcr_pkg for field widths
interface mcr_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [mcr_pkg::COORD_BITS-1:0] center_x;
  logic signed [mcr_pkg::COORD_BITS-1:0] center_y;
  logic signed [mcr_pkg::COORD_BITS-1:0] edge_x;
  logic signed [mcr_pkg::COORD_BITS-1:0] edge_y;

  modport source (output valid, command, center_x, center_y, edge_x, edge_y, input ready);
  modport sink   (input valid, command, center_x, center_y, edge_x, edge_y, output ready);
endinterface

[rtl/core/mcr_pix_if.sv]
// pixel channel: valid/ready handshake with one pixel per transaction
// depends on mcr_pkg for field widths
interface mcr_pix_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mcr_pkg::PIXEL_BITS-1:0]  pixel_x;
  logic signed [mcr_pkg::PIXEL_BITS-1:0]  pixel_y;
  logic        [mcr_pkg::COLOR_BITS-1:0]  pixel_color;
  logic        [mcr_pkg::MIRROR_BITS-1:0] mirror_index;
  logic                                  group_last;
  logic                                  circle_done;

  modport source (output valid, pixel_x, pixel_y, pixel_color, mirror_index, group_last,
                  circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, mirror_index, group_last,
                  circle_done, output ready);
endinterface

[rtl/core/midpoint_circle_raster.sv]
// midpoint circle rasterizer: start/step commands in, mirrored pixels out
// depends on mcr_pkg, mcr_cmd_if, mcr_pix_if
//
//   channel   dir  payload                                         handshake
//   in_cmd    in   command, center_x/y, edge_x/y                   valid/ready
//   out_pix   out  pixel_x/y, pixel_color, mirror_index, flags     valid/ready
//   cfg_*     in   cfg_wdata = draw color                          cfg_we, no stall
//
// a step is accepted, then its eight mirrored pixels go out, one pixel per cycle unless stalled
// a start is accepted, squares dx and dy on the shared squarer (ST_SQ_DX, ST_SQ_DY), runs
// the binary digit-by-digit square root loop (ST_ROOT), then emits its eight pixels
// a step with no circle in progress is taken and emits nothing
// in_cmd.ready is high only when idle; out_pix stalls simply hold the current pixel
// rst_n is synchronous and clears the sequencer, the mirror index, the active and done flags and the draw color
module midpoint_circle_raster (
  input  logic                          clk,
  input  logic                          rst_n,
  mcr_cmd_if.sink                       in_cmd,
  mcr_pix_if.source                     out_pix,
  input  logic                          cfg_we,
  input  logic [mcr_pkg::COLOR_BITS-1:0] cfg_wdata
);
  import mcr_pkg::*;

  state_t state_r, state_nxt;

  logic [COLOR_BITS-1:0]           color_r;
  logic signed [COORD_BITS-1:0]    origin_x_r, origin_x_nxt;
  logic signed [COORD_BITS-1:0]    origin_y_r, origin_y_nxt;
  logic [OFFSET_BITS-1:0]          offset_x_r, offset_x_nxt;
  logic [OFFSET_BITS-1:0]          offset_y_r, offset_y_nxt;
  logic [DECISION_BITS-1:0]        decision_r, decision_nxt;
  logic                            active_r, active_nxt;
  logic                            done_r, done_nxt;
  logic [MIRROR_BITS-1:0]          mirror_r, mirror_nxt;
  logic signed [DIFF_BITS-1:0]     dx_r, dx_nxt;
  logic signed [DIFF_BITS-1:0]     dy_r, dy_nxt;
  logic [SUM_BITS-1:0]             rem_r, rem_nxt;
  logic [SUM_BITS-1:0]             root_r, root_nxt;
  logic [SUM_BITS-1:0]             bit_r, bit_nxt;

  // shared squarer
  logic signed [DIFF_BITS-1:0]     mul_op;
  logic signed [SUM_BITS-1:0]      mul_ext;
  logic signed [SUM_BITS-1:0]      prod;

  // root loop
  logic [SUM_BITS-1:0]             trial;
  logic [SUM_BITS-1:0]             root_step;
  logic [SUM_BITS-1:0]             rem_step;

  // midpoint step
  logic [DECISION_BITS-1:0]        x_ext, y_ext, dec_step;
  logic [OFFSET_BITS-1:0]          step_x, step_y;

  // pixel mirroring
  logic [CALC_BITS-1:0]            org_x_ext, org_y_ext, off_a, off_b, pix_x, pix_y;
  logic                            neg_a, neg_b;

  logic in_fire, out_fire;

  assign in_fire  = in_cmd.valid && in_cmd.ready;
  assign out_fire = out_pix.valid && out_pix.ready;

  assign mul_op  = (state_r == ST_SQ_DX) ? dx_r : dy_r;
  assign mul_ext = SUM_BITS'(mul_op);
  assign prod    = mul_ext * mul_ext;

  assign trial = root_r + bit_r;
  always_comb begin
    if (rem_r >= trial) begin
      rem_step  = rem_r - trial;
      root_step = (root_r >> 1) + bit_r;
    end else begin
      rem_step  = rem_r;
      root_step = root_r >> 1;
    end
  end

  assign x_ext = DECISION_BITS'(offset_x_r);
  assign y_ext = DECISION_BITS'(offset_y_r);
  always_comb begin
    if (!decision_r[DECISION_BITS-1]) begin
      dec_step = decision_r + ((y_ext - x_ext) << 1) + DECISION_BITS'(5);
      step_x   = offset_x_r - OFFSET_BITS'(1);
    end else begin
      dec_step = decision_r + (y_ext << 1) + DECISION_BITS'(3);
      step_x   = offset_x_r;
    end
    step_y = offset_y_r + OFFSET_BITS'(1);
  end

  // mirrors 0..3 use (x, y), mirrors 4..7 use (y, x)
  assign neg_a     = mirror_r[0] ^ mirror_r[1];
  assign neg_b     = mirror_r[1];
  assign org_x_ext = CALC_BITS'(origin_x_r);
  assign org_y_ext = CALC_BITS'(origin_y_r);
  assign off_a     = mirror_r[2] ? CALC_BITS'(offset_y_r) : CALC_BITS'(offset_x_r);
  assign off_b     = mirror_r[2] ? CALC_BITS'(offset_x_r) : CALC_BITS'(offset_y_r);
  assign pix_x     = neg_a ? (org_x_ext - off_a) : (org_x_ext + off_a);
  assign pix_y     = neg_b ? (org_y_ext - off_b) : (org_y_ext + off_b);

  assign in_cmd.ready         = (state_r == ST_IDLE);
  assign out_pix.valid        = (state_r == ST_EMIT);
  assign out_pix.pixel_x      = pix_x[PIXEL_BITS-1:0];
  assign out_pix.pixel_y      = pix_y[PIXEL_BITS-1:0];
  assign out_pix.pixel_color  = color_r;
  assign out_pix.mirror_index = mirror_r;
  assign out_pix.group_last   = (mirror_r == LAST_MIRROR);
  assign out_pix.circle_done  = done_r;

  always_comb begin
    state_nxt    = state_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    offset_x_nxt = offset_x_r;
    offset_y_nxt = offset_y_r;
    decision_nxt = decision_r;
    active_nxt   = active_r;
    done_nxt     = done_r;
    mirror_nxt   = mirror_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    bit_nxt      = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd.command == CMD_START) begin
            origin_x_nxt = in_cmd.center_x;
            origin_y_nxt = in_cmd.center_y;
            dx_nxt       = DIFF_BITS'(in_cmd.edge_x) - DIFF_BITS'(in_cmd.center_x);
            dy_nxt       = DIFF_BITS'(in_cmd.edge_y) - DIFF_BITS'(in_cmd.center_y);
            state_nxt    = ST_SQ_DX;
          end else if (active_r) begin
            offset_x_nxt = step_x;
            offset_y_nxt = step_y;
            decision_nxt = dec_step;
            done_nxt     = !(step_y < step_x);
            active_nxt   = (step_y < step_x);
            mirror_nxt   = '0;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_SQ_DX: begin
        rem_nxt   = prod;
        state_nxt = ST_SQ_DY;
      end
      ST_SQ_DY: begin
        rem_nxt   = rem_r + prod;
        root_nxt  = '0;
        bit_nxt   = SUM_BITS'(1) << (SUM_BITS - 2);
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        rem_nxt  = rem_step;
        root_nxt = root_step;
        bit_nxt  = bit_r >> 2;
        // last digit of the root: load the first octant point
        if (bit_r[0]) begin
          offset_x_nxt = root_step[OFFSET_BITS-1:0];
          offset_y_nxt = '0;
          decision_nxt = DECISION_BITS'(1) - DECISION_BITS'(root_step[OFFSET_BITS-1:0]);
          done_nxt     = (root_step[OFFSET_BITS-1:0] == '0);
          active_nxt   = (root_step[OFFSET_BITS-1:0] != '0);
          mirror_nxt   = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (mirror_r == LAST_MIRROR) begin
            state_nxt = ST_IDLE;
          end else begin
            mirror_nxt = mirror_r + MIRROR_BITS'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
      done_r   <= 1'b0;
      mirror_r <= '0;
      color_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      done_r   <= done_nxt;
      mirror_r <= mirror_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    origin_x_r <= origin_x_nxt;
    origin_y_r <= origin_y_nxt;
    offset_x_r <= offset_x_nxt;
    offset_y_r <= offset_y_nxt;
    decision_r <= decision_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
  end

endmodule

[rtl/core/mcr_checker.sv]
// port-level checks for midpoint_circle_raster, attached by bind
// depends on mcr_pkg and assert_macros.svh
`include "assert_macros.svh"

module mcr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mcr_pkg::PIXEL_BITS-1:0]  pixel_x,
  input logic [mcr_pkg::PIXEL_BITS-1:0]  pixel_y,
  input logic [mcr_pkg::MIRROR_BITS-1:0] mirror_index,
  input logic                           group_last,
  input logic                           circle_done
);
  import mcr_pkg::*;

  logic out_fire;
  assign out_fire = out_valid && out_ready;

  // no new command is taken while a pixel group is going out
  `MCR_ASSERT_NOW(a_no_accept_while_emit, out_valid, !in_ready, "command ready during pixel output")

  // an accepted command never overlaps a pixel transaction
  `MCR_ASSERT_NOW(a_accept_only_idle, in_valid && in_ready, !out_valid,
    "command taken during pixel output")

  // a stalled pixel holds
  `MCR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(mirror_index),
    "stalled pixel changed")

  // a group runs through all eight mirrors back to back
  `MCR_ASSERT_NEXT(a_mirror_seq, out_fire && !group_last,
    out_valid && (mirror_index == $past(mirror_index) + MIRROR_BITS'(1))
    && (circle_done == $past(circle_done)),
    "mirror sequence broken within group")

  `MCR_ASSERT_NOW(a_last_flag, out_valid, group_last == (mirror_index == LAST_MIRROR),
    "group_last out of place")

endmodule

bind midpoint_circle_raster mcr_checker u_mcr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_cmd.valid),
  .in_ready     (in_cmd.ready),
  .out_valid    (out_pix.valid),
  .out_ready    (out_pix.ready),
  .pixel_x      (out_pix.pixel_x),
  .pixel_y      (out_pix.pixel_y),
  .mirror_index (out_pix.mirror_index),
  .group_last   (out_pix.group_last),
  .circle_done  (out_pix.circle_done)
);

[test/tb_midpoint_circle_raster.sv]
`timescale 1ns / 100ps
// self-checking testbench for midpoint_circle_raster: start/step commands, mirrored pixel out
// depends on mcr_pkg, mcr_cmd_if, mcr_pix_if and the rasterizer itself
module tb_midpoint_circle_raster;
  import mcr_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int RUN_ITEMS   = 88;
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   command;
    coord_t center_x;
    coord_t center_y;
    coord_t edge_x;
    coord_t edge_y;
  } circle_cmd_t;

  typedef struct {
    logic signed [PIXEL_BITS-1:0] x;
    logic signed [PIXEL_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic [MIRROR_BITS-1:0]       mirror;
    logic                         last;
    logic                         done;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [COLOR_BITS-1:0] cfg_wdata;

  mcr_cmd_if cmd_ch ();
  mcr_pix_if pix_ch ();

  midpoint_circle_raster u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (cmd_ch),
    .out_pix  (pix_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  int                           org_x;
  int                           org_y;
  logic [OFFSET_BITS-1:0]       arc_x;
  logic [OFFSET_BITS-1:0]       arc_y;
  logic signed [DECISION_BITS-1:0] arc_dec;
  logic                         circle_on;
  logic [COLOR_BITS-1:0]        ink;

  circle_cmd_t pending_cmds[$];
  pixel_t      expected_pixels[$];
  circle_cmd_t on_wire;

  int cycle_count;
  int errors;
  int cmds_queued;
  int cmds_taken;
  int items_made;
  int src_idle_pct;
  int snk_idle_pct;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit idle_roll(input int pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  function automatic int root_floor(input int n);
    int r;
    r = 0;
    for (int b = OFFSET_BITS - 1; b >= 0; b--) begin
      if ((r + (1 << b)) * (r + (1 << b)) <= n) r += 1 << b;
    end
    return r;
  endfunction

  task automatic plot_group(input bit done);
    int ax;
    int ay;
    int px;
    int py;
    pixel_t p;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin ax = arc_x;  ay = arc_y;  end
        1: begin ax = -arc_x; ay = arc_y;  end
        2: begin ax = -arc_x; ay = -arc_y; end
        3: begin ax = arc_x;  ay = -arc_y; end
        4: begin ax = arc_y;  ay = arc_x;  end
        5: begin ax = -arc_y; ay = arc_x;  end
        6: begin ax = -arc_y; ay = -arc_x; end
        default: begin ax = arc_y; ay = -arc_x; end
      endcase
      px = org_x + ax;
      py = org_y + ay;
      p.x      = px[PIXEL_BITS-1:0];
      p.y      = py[PIXEL_BITS-1:0];
      p.color  = ink;
      p.mirror = k[MIRROR_BITS-1:0];
      p.last   = (p.mirror == LAST_MIRROR);
      p.done   = done;
      expected_pixels.push_back(p);
    end
  endtask

  task automatic predict_pixels(input circle_cmd_t c);
    int dx;
    int dy;
    int x;
    int y;
    int d;
    bit done;
    if (c.command == CMD_START) begin
      dx = int'(c.edge_x) - int'(c.center_x);
      dy = int'(c.edge_y) - int'(c.center_y);
      x = root_floor(dx * dx + dy * dy);
      org_x   = c.center_x;
      org_y   = c.center_y;
      arc_x   = x[OFFSET_BITS-1:0];
      arc_y   = '0;
      d       = 1 - x;
      arc_dec = d[DECISION_BITS-1:0];
    end else begin
      // a step with no circle in progress is swallowed
      if (!circle_on) return;
      x = arc_x;
      y = arc_y;
      d = arc_dec;
      if (d >= 0) begin
        d = d + 2 * (y - x) + 5;
        x--;
      end else begin
        d = d + 2 * y + 3;
      end
      y++;
      arc_x   = x[OFFSET_BITS-1:0];
      arc_y   = y[OFFSET_BITS-1:0];
      arc_dec = d[DECISION_BITS-1:0];
    end
    done = !(arc_y < arc_x);
    circle_on = !done;
    plot_group(done);
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_pixels(on_wire);
        cmds_taken++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() > 0 && !idle_roll(src_idle_pct)) begin
          on_wire = pending_cmds.pop_front();
          cmd_ch.valid    <= 1'b1;
          cmd_ch.command  <= on_wire.command;
          cmd_ch.center_x <= on_wire.center_x;
          cmd_ch.center_y <= on_wire.center_y;
          cmd_ch.edge_x   <= on_wire.edge_x;
          cmd_ch.edge_y   <= on_wire.edge_y;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel (%0d,%0d) mirror %0d",
                                    pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.mirror_index));
        end else begin
          want = expected_pixels.pop_front();
          if (pix_ch.pixel_x !== want.x)
            report_mismatch($sformatf("pixel_x %0d, want %0d (mirror %0d)",
                                      pix_ch.pixel_x, want.x, want.mirror));
          if (pix_ch.pixel_y !== want.y)
            report_mismatch($sformatf("pixel_y %0d, want %0d (mirror %0d)",
                                      pix_ch.pixel_y, want.y, want.mirror));
          if (pix_ch.pixel_color !== want.color)
            report_mismatch($sformatf("pixel_color %06h, want %06h",
                                      pix_ch.pixel_color, want.color));
          if (pix_ch.mirror_index !== want.mirror)
            report_mismatch($sformatf("mirror_index %0d, want %0d",
                                      pix_ch.mirror_index, want.mirror));
          if (pix_ch.group_last !== want.last)
            report_mismatch($sformatf("group_last %0b, want %0b (mirror %0d)",
                                      pix_ch.group_last, want.last, want.mirror));
          if (pix_ch.circle_done !== want.done)
            report_mismatch($sformatf("circle_done %0b, want %0b (mirror %0d)",
                                      pix_ch.circle_done, want.done, want.mirror));
        end
      end
      pix_ch.ready <= !idle_roll(snk_idle_pct);
    end
  end

  task automatic push_cmd(input logic command, input int cx, input int cy,
                          input int ex, input int ey);
    circle_cmd_t c;
    c.command  = command;
    c.center_x = cx[COORD_BITS-1:0];
    c.center_y = cy[COORD_BITS-1:0];
    c.edge_x   = ex[COORD_BITS-1:0];
    c.edge_y   = ey[COORD_BITS-1:0];
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  function automatic int any_coord();
    return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  // coordinates of a step are ignored, so they carry random content
  task automatic push_step();
    push_cmd(CMD_STEP, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  function automatic int near_coord(input int c, input int delta);
    if (c + delta > COORD_MAX || c + delta < COORD_MIN) return c - delta;
    return c + delta;
  endfunction

  // one start followed by a run of steps, mostly carried to the end of the octant
  task automatic queue_circle_run();
    int cx;
    int cy;
    int ex;
    int ey;
    int r;
    int steps;
    cx = any_coord();
    cy = any_coord();
    if ($urandom_range(0, 99) < 85) begin
      ex = near_coord(cx, int'($urandom_range(0, 50)) - 25);
      ey = near_coord(cy, int'($urandom_range(0, 50)) - 25);
    end else begin
      ex = any_coord();
      ey = any_coord();
    end
    r = root_floor((ex - cx) * (ex - cx) + (ey - cy) * (ey - cy));
    if (r > 40) steps = $urandom_range(0, 6);
    else if ($urandom_range(0, 3) != 0) steps = r * 3 / 4 + 2;
    else steps = $urandom_range(0, r * 3 / 4 + 1);
    push_cmd(CMD_START, cx, cy, ex, ey);
    repeat (steps) push_step();
    items_made += 1 + steps;
    // noise: stray steps, usually landing on an idle block
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) push_step();
  endtask

  task automatic drain();
    while (cmds_taken != cmds_queued) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_color(input logic [COLOR_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    ink = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int src_pct, input int snk_pct,
                              input logic [COLOR_BITS-1:0] color);
    write_color(color);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    items_made = 0;
    while (items_made < RUN_ITEMS) queue_circle_run();
    drain();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = CMD_START;
    cmd_ch.center_x = '0;
    cmd_ch.center_y = '0;
    cmd_ch.edge_x   = '0;
    cmd_ch.edge_y   = '0;
    pix_ch.ready    = 1'b0;
    cycle_count     = 0;
    errors          = 0;
    cmds_queued     = 0;
    cmds_taken      = 0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    org_x           = 0;
    org_y           = 0;
    arc_x           = '0;
    arc_y           = '0;
    arc_dec         = '0;
    circle_on       = 1'b0;
    ink             = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with the color left by reset
    push_step();                                                // step right after reset
    push_cmd(CMD_START, 0, 0, 0, 0);                            // zero radius
    push_step();                                                // step while idle
    push_cmd(CMD_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    push_step();
    push_step();
    push_cmd(CMD_START, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);  // restart while active
    push_step();
    push_cmd(CMD_START, 100, -50, 101, -50);                    // radius one
    push_step();
    push_step();
    push_cmd(CMD_START, -5, 7, -5, -3);                         // radius ten, run to the end
    repeat (8) push_step();
    push_cmd(CMD_START, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    push_step();
    push_cmd(CMD_START, 0, 0, 3, 4);
    push_step();
    push_step();
    drain();

    random_phase(0, 0, {COLOR_BITS{1'b1}});
    random_phase(87, 0, '0);
    random_phase(0, 87, COLOR_BITS'($urandom));
    random_phase(18, 18, 24'hA5C35A);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mcr_pkg.sv
rtl/core/mcr_cmd_if.sv
rtl/core/mcr_pix_if.sv
rtl/core/midpoint_circle_raster.sv
rtl/core/mcr_checker.sv
test/tb_midpoint_circle_raster.sv
